// ===== src/dtq_pkg.sv =====
package dtq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned IDXW        = $clog2(DEPTH);
  localparam int unsigned CNTW        = $clog2(MAX_RESULTS + 1);
  localparam int unsigned TIMEW       = 48;
  localparam int unsigned ORDW        = 32;
  localparam int unsigned TAGW        = 16;
  localparam int unsigned DLYW        = 32;
  localparam int unsigned KINDW       = 2;
  localparam int unsigned STW         = 3;

  localparam logic [KINDW-1:0] KindPost     = 2'd0;
  localparam logic [KINDW-1:0] KindTick     = 2'd1;
  localparam logic [KINDW-1:0] KindShutdown = 2'd2;

  localparam logic [STW-1:0] StFired    = 3'd0;
  localparam logic [STW-1:0] StAccepted = 3'd1;
  localparam logic [STW-1:0] StStopped  = 3'd2;
  localparam logic [STW-1:0] StFull     = 3'd3;
  localparam logic [STW-1:0] StShutdown = 3'd4;

  typedef struct packed {
    logic load_in;
    logic do_post;
    logic do_shut;
    logic tick_start;
    logic scan_step;
    logic take_best;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_last;
    logic best_valid;
    logic pending_valid;
    logic count_last;
  } sts_t;

endpackage

// ===== src/dtq_datapath.sv =====
module dtq_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dtq_pkg::cmd_t              cmd_i,
  output dtq_pkg::sts_t              sts_o,
  input  logic [dtq_pkg::TAGW-1:0]   in_tag_i,
  input  logic [dtq_pkg::DLYW-1:0]   in_delay_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dtq_pkg::STW-1:0]    out_status_o,
  output logic [dtq_pkg::TAGW-1:0]   out_tag_o,
  output logic                       out_last_o
);
  import dtq_pkg::*;

  logic [TIMEW-1:0] now_q, now_d;
  logic [ORDW-1:0]  order_q;
  logic             stopped_q;
  logic [DEPTH-1:0] valid_q;
  logic [TIMEW-1:0] dl_q  [DEPTH];
  logic [ORDW-1:0]  ord_q [DEPTH];
  logic [TAGW-1:0]  tag_q [DEPTH];

  logic [TAGW-1:0]  in_tag_q;
  logic [DLYW-1:0]  in_delay_q;

  logic [IDXW-1:0]  scan_idx_q;
  logic             best_valid_q;
  logic [IDXW-1:0]  best_idx_q;
  logic [TIMEW-1:0] best_dl_q;
  logic [ORDW-1:0]  best_ord_q;
  logic [TAGW-1:0]  best_tag_q;
  logic             pend_valid_q;
  logic [TAGW-1:0]  pend_tag_q;
  logic [CNTW-1:0]  count_q;

  logic             out_valid_q, out_valid_d;
  logic [STW-1:0]   out_status_q, out_status_d;
  logic [TAGW-1:0]  out_tag_q, out_tag_d;
  logic             out_last_q, out_last_d;
  logic             out_load;
  logic             out_free;

  logic             free_found;
  logic [IDXW-1:0]  free_idx;
  logic [DLYW-1:0]  dly;
  logic [TIMEW:0]   dl_sum;
  logic [TIMEW-1:0] dl_new;
  logic             post_ok;

  logic [TIMEW-1:0] cur_dl;
  logic [ORDW-1:0]  cur_ord;
  logic             eligible;
  logic             better;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDXW'(i);
      end
    end
  end

  assign dly     = in_delay_q[DLYW-1] ? '0 : in_delay_q;
  assign dl_sum  = {1'b0, now_q} + {{(TIMEW - DLYW + 1){1'b0}}, dly};
  assign dl_new  = dl_sum[TIMEW] ? '1 : dl_sum[TIMEW-1:0];
  assign post_ok = !stopped_q && free_found;

  assign cur_dl   = dl_q[scan_idx_q];
  assign cur_ord  = ord_q[scan_idx_q];
  assign eligible = valid_q[scan_idx_q] && (cur_dl <= now_q);
  assign better   = !best_valid_q || (cur_dl < best_dl_q) ||
                    ((cur_dl == best_dl_q) && (cur_ord < best_ord_q));

  assign now_d = (now_q == '1) ? now_q : now_q + TIMEW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      order_q      <= '0;
      stopped_q    <= 1'b0;
      valid_q      <= '0;
      scan_idx_q   <= '0;
      best_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      count_q      <= '0;
    end else begin
      if (cmd_i.do_post && post_ok) begin
        valid_q[free_idx] <= 1'b1;
        order_q           <= order_q + ORDW'(1);
      end
      if (cmd_i.do_shut) begin
        valid_q   <= '0;
        stopped_q <= 1'b1;
      end
      if (cmd_i.tick_start) begin
        now_q        <= now_d;
        scan_idx_q   <= '0;
        best_valid_q <= 1'b0;
        pend_valid_q <= 1'b0;
        count_q      <= '0;
      end
      if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + IDXW'(1);
        if (eligible && better) begin
          best_valid_q <= 1'b1;
        end
      end
      if (cmd_i.take_best) begin
        valid_q[best_idx_q] <= 1'b0;
        pend_valid_q        <= 1'b1;
        count_q             <= count_q + CNTW'(1);
        scan_idx_q          <= '0;
        best_valid_q        <= 1'b0;
      end
      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_tag_q   <= in_tag_i;
      in_delay_q <= in_delay_i;
    end
    if (cmd_i.do_post && post_ok) begin
      dl_q[free_idx]  <= dl_new;
      ord_q[free_idx] <= order_q;
      tag_q[free_idx] <= in_tag_q;
    end
    if (cmd_i.scan_step && eligible && better) begin
      best_idx_q <= scan_idx_q;
      best_dl_q  <= cur_dl;
      best_ord_q <= cur_ord;
      best_tag_q <= tag_q[scan_idx_q];
    end
    if (cmd_i.take_best) begin
      pend_tag_q <= best_tag_q;
    end
  end

  // result word register
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.do_post || cmd_i.do_shut || cmd_i.flush ||
                    (cmd_i.take_best && pend_valid_q);

  always_comb begin
    out_status_d = out_status_q;
    out_tag_d    = out_tag_q;
    out_last_d   = out_last_q;
    if (cmd_i.do_post) begin
      out_status_d = stopped_q ? StStopped : (free_found ? StAccepted : StFull);
      out_tag_d    = '0;
      out_last_d   = 1'b1;
    end else if (cmd_i.do_shut) begin
      out_status_d = StShutdown;
      out_tag_d    = '0;
      out_last_d   = 1'b1;
    end else if (cmd_i.flush || cmd_i.take_best) begin
      out_status_d = StFired;
      out_tag_d    = pend_tag_q;
      out_last_d   = cmd_i.flush;
    end
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_tag_q    <= out_tag_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_tag_o    = out_tag_q;
  assign out_last_o   = out_last_q;

  assign sts_o.out_free      = out_free;
  assign sts_o.scan_last     = (scan_idx_q == IDXW'(DEPTH - 1));
  assign sts_o.best_valid    = best_valid_q;
  assign sts_o.pending_valid = pend_valid_q;
  assign sts_o.count_last    = (count_q == CNTW'(MAX_RESULTS - 1));

endmodule

// ===== src/dtq_ctrl.sv =====
module dtq_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [dtq_pkg::KINDW-1:0] in_kind_i,
  input  dtq_pkg::sts_t             sts_i,
  output dtq_pkg::cmd_t             cmd_o
);
  import dtq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_POST    = 7'b0000010,
    S_SHUT    = 7'b0000100,
    S_TICK    = 7'b0001000,
    S_SCAN    = 7'b0010000,
    S_RESOLVE = 7'b0100000,
    S_FLUSH   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          case (in_kind_i)
            KindPost:     state_d = S_POST;
            KindTick:     state_d = S_TICK;
            KindShutdown: state_d = S_SHUT;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_POST: begin
        if (sts_i.out_free) begin
          cmd_o.do_post = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_SHUT: begin
        if (sts_i.out_free) begin
          cmd_o.do_shut = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_TICK: begin
        cmd_o.tick_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (sts_i.best_valid) begin
          if (!sts_i.pending_valid || sts_i.out_free) begin
            cmd_o.take_best = 1'b1;
            state_d         = sts_i.count_last ? S_FLUSH : S_SCAN;
          end
        end else begin
          state_d = sts_i.pending_valid ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/deadline_timer_queue.sv =====
// Deadline-ordered timer queue of tagged tasks.
// Input channel (s_axis): tuser = kind (post, tick, shutdown); tdata = task_tag in
// bits 15:0, signed delay in bits 47:16. Output channel (m_axis): tuser = status,
// tdata = fired_tag, tlast marks the final word caused by one input word.
// A post answers with one status word, and the input is ready again in the same
// cycle that this word becomes valid; a shutdown clears the table, stops further
// posting and answers likewise; the unused kind answers nothing and leaves the
// input ready again in the next cycle.
// A tick advances the millisecond clock, then scans the table, one entry per cycle,
// once per fired task and once more to find none left; at most 16 tasks fire in
// one tick, and after the sixteenth no further scan runs. The scan over the entry
// table sets the length of a tick; one word is handled at a time.
// Fired words come out in deadline order, ties by posting order.
// Results pass through an output register: a stalled receiver holds the block
// only when a new result word must be written while the register is still full.
// Reset clears the clock, the order counter, the stopped flag and all entry
// valid bits at once; no clearing pass is needed.
module deadline_timer_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // task_tag[15:0], delay[47:16]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // fired_tag[15:0]
  output logic [2:0]  m_axis_tuser,  // status[2:0]
  output logic        m_axis_tlast
);
  import dtq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dtq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_tag_i     (s_axis_tdata[TAGW-1:0]),
    .in_delay_i   (s_axis_tdata[TAGW+DLYW-1:TAGW]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_tag_o    (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule
